// ===== sv/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared constants and types for the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int BYTE_W         = 8;
  localparam int LIMIT_W        = 24;
  localparam int COUNT_BITS_DEF = 24;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);

  localparam logic [WIN_AW-1:0] WR_POS_INIT = WIN_AW'(12'hFEE);

  localparam int LEN_W    = 5;   // match length 3..18
  localparam int LEN_BIAS = 3;

  localparam int FLAG_W = 9;
  localparam logic [FLAG_W-1:0] FLAG_MARK = 9'h100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LIT,
    ST_COPY,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_TOKEN,
    PH_MATCH_HI
  } phase_t;

endpackage

// ===== sv/lzss_ifs.sv =====
// ----------------------------------------------------------------------------
// lzss channel interfaces
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface lzss_in_if;
  import lzss_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface lzss_out_if;
  import lzss_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic              run_last;
  logic              done_res;
  logic              length_error;

  modport source (output valid, output out_byte, output out_valid, output run_last,
                  output done_res, output length_error, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input run_last,
                  input done_res, input length_error, output ready);
endinterface

// ===== sv/lzss_stream_decompressor_top.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top
// LZSS decoder with a 4 KB sliding window, one compressed byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : one compressed byte per transaction, last_in marks the stream end.
//   out_m : decoded bytes, one per transaction, through a one-entry output
//           register. run_last tags the last result caused by an input byte;
//           done_res/length_error ride on the last result of the stream.
//   cfg_we/cfg_data : output_limit, write only between transactions.
// Steps per input byte:
//   flag byte or first match byte : accept, decode
//   literal                       : accept, decode, emit
//   second match byte, n copied   : accept, decode, copy of n bytes
//   Rate is set by the single window RAM port pair: one byte read and one
//   byte written per cycle during a copy while the output register is free,
//   with a forward path for copies that overlap the bytes being written.
// Reset: synchronous, active low. The window needs no clearing pass: a fill
//   count tracks how much of it was written since the stream began, and
//   anything outside that range reads as zero. The same holds after the last
//   byte of every stream, so the next stream can start right away.
// Receiver stall: the sequencer holds (read pipeline included) until the
//   output register frees; in_s.ready stays low while an item is in work.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top #(
  parameter int COUNT_BITS = lzss_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lzss_in_if.sink                      in_s,
  lzss_out_if.source                   out_m,
  input  logic                         cfg_we,
  input  logic [lzss_pkg::LIMIT_W-1:0] cfg_data
);
  import lzss_pkg::*;

  // sequencer and parser state
  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [FLAG_W-1:0]    flag_r, flag_nxt;
  logic [BYTE_W-1:0]    off_lo_r, off_lo_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] limit_r;
  logic                 stop_r, stop_nxt;
  logic                 early_r, early_nxt;
  logic [WIN_AW-1:0]    wp_r, wp_nxt;
  logic [WIN_AW:0]      fill_r, fill_nxt;     // bytes of window written, saturates

  // captured input transaction
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic                 last_r, last_nxt;

  // copy engine
  logic [WIN_AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;       // reads still to issue
  logic                 pv_r, pv_nxt;         // read data stage holds a byte
  logic [BYTE_W-1:0]    rdata_r;
  logic                 rv_r;                 // read address was inside fill range
  logic                 byp_hit_r;
  logic [BYTE_W-1:0]    byp_data_r;

  // output register
  logic                 ov_r, ov_nxt;
  logic [BYTE_W-1:0]    o_byte_r, o_byte_nxt;
  logic                 o_valid_r, o_valid_nxt;
  logic                 o_last_r, o_last_nxt;
  logic                 o_done_r, o_done_nxt;
  logic                 o_err_r, o_err_nxt;

  logic [BYTE_W-1:0]    win_mem [WIN_DEPTH];

  // decode helpers
  logic                 borrow;
  logic [COUNT_BITS-1:0] room;
  logic                 at_limit;
  logic [FLAG_W-1:0]    fb_shift;
  logic                 flag_load;
  logic                 tok_bit;
  logic                 is_flag, is_match_hi, is_token;
  logic [LEN_W-1:0]     mlen;
  logic [LEN_W-1:0]     copy_n;
  logic                 dec_lit, dec_copy;

  // datapath controls
  logic                 slot_free;
  logic                 accept;
  logic                 emit, emit_is_byte, emit_final;
  logic [BYTE_W-1:0]    emit_data;
  logic [BYTE_W-1:0]    copy_data;
  logic [COUNT_BITS-1:0] cnt_after;
  logic                 rd_en;
  logic                 rd_in_fill;
  logic [WIN_AW-1:0]    rd_dist;

  assign slot_free = !ov_r || out_m.ready;
  assign accept    = in_s.valid && in_s.ready;

  // --------------------------------------------------------------------------
  // Token decode of the captured byte
  // --------------------------------------------------------------------------
  always_comb begin
    {borrow, room} = {1'b0, limit_r} - {1'b0, cnt_r};
    at_limit       = borrow || (room == '0);
    fb_shift       = flag_r >> 1;
    flag_load      = (fb_shift < FLAG_W'(2));
    tok_bit        = (phase_r == PH_TOKEN) ? flag_r[0] : fb_shift[0];
    is_flag        = !stop_r && (phase_r == PH_START) && flag_load;
    is_match_hi    = !stop_r && (phase_r == PH_MATCH_HI);
    is_token       = !stop_r && !is_flag && !is_match_hi;
    mlen           = LEN_W'(byte_r[3:0]) + LEN_W'(LEN_BIAS);
    // copy length is the match length clipped to what the limit leaves
    if (at_limit) begin
      copy_n = '0;
    end else if (((room >> LEN_W) == '0) && (room[LEN_W-1:0] < mlen)) begin
      copy_n = room[LEN_W-1:0];
    end else begin
      copy_n = mlen;
    end
    dec_lit  = is_token && tok_bit && !at_limit;
    dec_copy = is_match_hi && (copy_n != '0);
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (dec_lit) begin
          state_nxt = ST_LIT;
        end else if (dec_copy) begin
          state_nxt = ST_COPY;
        end else if (last_r) begin
          state_nxt = ST_FIN;       // no byte out, still owe the done result
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        if (pv_r && slot_free && (rem_r == '0)) state_nxt = ST_IDLE;
      end
      ST_FIN: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath
  // --------------------------------------------------------------------------
  assign copy_data  = byp_hit_r ? byp_data_r : (rv_r ? rdata_r : '0);
  assign rd_dist    = rd_addr_r - WR_POS_INIT;
  assign rd_in_fill = ({1'b0, rd_dist} < fill_r);

  always_comb begin
    phase_nxt   = phase_r;
    flag_nxt    = flag_r;
    off_lo_nxt  = off_lo_r;
    cnt_nxt     = cnt_r;
    stop_nxt    = stop_r;
    early_nxt   = early_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    rd_addr_nxt = rd_addr_r;
    rem_nxt     = rem_r;
    pv_nxt      = pv_r;
    ov_nxt      = ov_r;
    o_byte_nxt  = o_byte_r;
    o_valid_nxt = o_valid_r;
    o_last_nxt  = o_last_r;
    o_done_nxt  = o_done_r;
    o_err_nxt   = o_err_r;

    emit         = 1'b0;
    emit_is_byte = 1'b0;
    emit_final   = 1'b0;
    emit_data    = byte_r;
    rd_en        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          byte_nxt = in_s.in_byte;
          last_nxt = in_s.last_in;
        end
      end
      ST_DECODE: begin
        pv_nxt = 1'b0;
        if (stop_r) begin
          early_nxt = 1'b1;         // input left over after output stopped
        end else if (is_match_hi) begin
          rd_addr_nxt = {byte_r[BYTE_W-1:4], off_lo_r};
          rem_nxt     = copy_n;
          phase_nxt   = PH_START;
          if (copy_n != mlen) stop_nxt = 1'b1;
        end else begin
          if (phase_r == PH_START) flag_nxt = fb_shift;
          if (is_flag) begin
            flag_nxt  = FLAG_MARK | FLAG_W'(byte_r);
            phase_nxt = PH_TOKEN;
          end else if (tok_bit) begin
            if (at_limit) begin
              stop_nxt  = 1'b1;
              early_nxt = 1'b1;
            end else begin
              phase_nxt = PH_START;
            end
          end else begin
            off_lo_nxt = byte_r;
            phase_nxt  = PH_MATCH_HI;
          end
        end
      end
      ST_LIT: begin
        emit         = slot_free;
        emit_is_byte = 1'b1;
        emit_final   = 1'b1;
        emit_data    = byte_r;
      end
      ST_COPY: begin
        emit         = pv_r && slot_free;
        emit_is_byte = 1'b1;
        emit_final   = (rem_r == '0);
        emit_data    = copy_data;
        rd_en        = (rem_r != '0) && (!pv_r || slot_free);
        if (rd_en) begin
          rd_addr_nxt = rd_addr_r + 1'b1;
          rem_nxt     = rem_r - 1'b1;
        end
        pv_nxt = rd_en || (pv_r && !emit);
      end
      ST_FIN: begin
        emit       = slot_free;
        emit_final = 1'b1;
      end
      default: ;
    endcase

    cnt_after = emit_is_byte ? (cnt_r + 1'b1) : cnt_r;

    if (emit) begin
      ov_nxt      = 1'b1;
      o_byte_nxt  = emit_is_byte ? emit_data : '0;
      o_valid_nxt = emit_is_byte;
      o_last_nxt  = emit_final;
      o_done_nxt  = emit_final && last_r;
      o_err_nxt   = emit_final && last_r && ((cnt_after != limit_r) || early_r);
      if (emit_is_byte) begin
        cnt_nxt = cnt_after;
        wp_nxt  = wp_r + 1'b1;
        if (fill_r != (WIN_AW+1)'(WIN_DEPTH)) fill_nxt = fill_r + 1'b1;
      end
      // end of stream: parser, counters and window back to their start
      if (emit_final && last_r) begin
        phase_nxt  = PH_START;
        flag_nxt   = '0;
        off_lo_nxt = '0;
        cnt_nxt    = '0;
        stop_nxt   = 1'b0;
        early_nxt  = 1'b0;
        wp_nxt     = WR_POS_INIT;
        fill_nxt   = '0;
      end
    end else if (out_m.ready) begin
      ov_nxt = 1'b0;
    end
  end

  // stream end with no result-producing work goes through ST_FIN, so the
  // decode-only path never needs the stream reset itself

  assign in_s.ready         = (state_r == ST_IDLE);
  assign out_m.valid        = ov_r;
  assign out_m.out_byte     = o_byte_r;
  assign out_m.out_valid    = o_valid_r;
  assign out_m.run_last     = o_last_r;
  assign out_m.done_res     = o_done_r;
  assign out_m.length_error = o_err_r;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_START;
      flag_r  <= '0;
      off_lo_r <= '0;
      cnt_r   <= '0;
      limit_r <= '0;
      stop_r  <= 1'b0;
      early_r <= 1'b0;
      wp_r    <= WR_POS_INIT;
      fill_r  <= '0;
      rem_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      flag_r   <= flag_nxt;
      off_lo_r <= off_lo_nxt;
      cnt_r    <= cnt_nxt;
      stop_r   <= stop_nxt;
      early_r  <= early_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      rem_r    <= rem_nxt;
      pv_r     <= pv_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) limit_r <= COUNT_BITS'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    rd_addr_r <= rd_addr_nxt;
    o_byte_r  <= o_byte_nxt;
    o_valid_r <= o_valid_nxt;
    o_last_r  <= o_last_nxt;
    o_done_r  <= o_done_nxt;
    o_err_r   <= o_err_nxt;
  end

  // window RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (emit && emit_is_byte) win_mem[wp_r] <= emit_data;
    if (rd_en) begin
      rdata_r    <= win_mem[rd_addr_r];
      rv_r       <= rd_in_fill;
      // read and write of the same entry this cycle: forward the new byte
      byp_hit_r  <= emit && emit_is_byte && (wp_r == rd_addr_r);
      byp_data_r <= emit_data;
    end
  end

endmodule

// ===== sv/lzss_checker.sv =====
// ----------------------------------------------------------------------------
// lzss_checker
// Port-level checks on the LZSS decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_vld,
  input logic                         out_rdy,
  input logic [lzss_pkg::BYTE_W-1:0]  out_byte,
  input logic                         out_valid,
  input logic                         run_last,
  input logic                         done_res,
  input logic                         length_error
);
  import lzss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(out_valid)
      && $stable(run_last) && $stable(done_res) && $stable(length_error))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_valid |-> done_res && run_last && (out_byte == '0))
    else $error("byteless result without stream end");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && done_res |-> run_last)
    else $error("done on a result that is not the item's last");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && length_error |-> done_res)
    else $error("length error outside stream end");

endmodule

bind lzss_stream_decompressor_top lzss_checker u_lzss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_s.valid),
  .in_ready     (in_s.ready),
  .out_vld      (out_m.valid),
  .out_rdy      (out_m.ready),
  .out_byte     (out_m.out_byte),
  .out_valid    (out_m.out_valid),
  .run_last     (out_m.run_last),
  .done_res     (out_m.done_res),
  .length_error (out_m.length_error)
);

// ===== sim/lzss_stream_decompressor_top_tb.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top_tb
// Self-checking bench: drives compressed LZSS streams with random gaps, decodes
// them in a local model of the 4 KB window and compares every result.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  localparam int    MAX_MATCH    = 18;        // 15 + LEN_BIAS
  localparam int    DRAIN_CYCLES = 30;        // lets result-less bytes finish
  localparam int    RAND_ITEMS   = 300;
  localparam int    HOLD_CYCLES  = 400;       // one long receiver hold-off
  localparam int    HOLD_AFTER   = 60;        // results seen before the hold-off
  localparam int    BIG_LIMIT    = 150;
  localparam longint TIMEOUT_NS  = 64'd5_000_000;

  // one compressed byte as the sender offers it
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } comp_byte_t;

  // one decoded result
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              run_last;
    logic              done;
    logic              len_err;
  } decoded_t;

  // shapes of generated streams
  typedef enum {
    SK_EXACT,   // decodes to exactly the limit
    SK_OVER,    // runs past the limit
    SK_SHORT,   // stops before the limit
    SK_CUT,     // final byte dropped, may end mid-token
    SK_NOISE    // random bytes
  } stream_kind_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  lzss_in_if  in_if ();
  lzss_out_if out_if ();

  lzss_stream_decompressor_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_if),
    .out_m    (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  comp_byte_t pending_bytes[$];   // bytes waiting for the driver
  decoded_t   decoded_q[$];       // expected results, oldest first
  decoded_t   step_out[$];        // results of the byte being decoded
  int         mismatches = 0;

  // ---------------------------------------------------------------------------
  // Decoder model state
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  win_mem [WIN_DEPTH];
  logic [WIN_AW-1:0]  wr_pos;
  logic [FLAG_W-1:0]  flags;       // unused flag bits under the marker bit
  phase_t             phase;
  logic [BYTE_W-1:0]  off_lo;
  logic [LIMIT_W-1:0] byte_count;
  logic               halted;
  logic               halted_early;
  logic [LIMIT_W-1:0] limit_reg;

  function automatic void clear_stream();
    foreach (win_mem[i]) win_mem[i] = '0;
    wr_pos       = WR_POS_INIT;
    flags        = '0;
    phase        = PH_START;
    off_lo       = '0;
    byte_count   = '0;
    halted       = 1'b0;
    halted_early = 1'b0;
  endfunction

  function automatic void emit_byte(input logic [BYTE_W-1:0] b);
    step_out.push_back('{data: b, valid: 1'b1, run_last: 1'b0, done: 1'b0, len_err: 1'b0});
    win_mem[wr_pos] = b;
    wr_pos          = wr_pos + 1'b1;
    byte_count      = byte_count + 1'b1;
  endfunction

  // literal or first match byte, as the current flag bit says
  function automatic void take_token(input logic [BYTE_W-1:0] b);
    if (flags[0]) begin
      if (byte_count >= limit_reg) begin
        // literal at the limit is not consumed; counts as left-over input
        halted       = 1'b1;
        halted_early = 1'b1;
      end else begin
        emit_byte(b);
        phase = PH_START;
      end
    end else begin
      off_lo = b;
      phase  = PH_MATCH_HI;
    end
  endfunction

  // decode one accepted byte and queue the results it causes
  function automatic void decode_step(input logic [BYTE_W-1:0] b, input logic last);
    logic [WIN_AW-1:0] src;
    int                len;
    decoded_t          tail;
    step_out.delete();
    if (halted) begin
      halted_early = 1'b1;
    end else if (phase == PH_MATCH_HI) begin
      src = {b[7:4], off_lo};
      len = int'(b[3:0]) + LEN_BIAS;
      // byte-by-byte copy, so overlapping sources see fresh bytes
      for (int i = 0; i < len; i++) begin
        if (byte_count >= limit_reg) begin
          halted = 1'b1;
          break;
        end
        emit_byte(win_mem[WIN_AW'(src + i)]);
      end
      phase = PH_START;
    end else if (phase == PH_TOKEN) begin
      take_token(b);
    end else begin
      flags = flags >> 1;
      if (flags < 2) begin
        flags = FLAG_MARK | FLAG_W'(b);
        phase = PH_TOKEN;
      end else begin
        take_token(b);
      end
    end
    if (last && step_out.size() == 0) step_out.push_back('0);
    if (step_out.size() != 0) begin
      tail          = step_out[$];
      tail.run_last = 1'b1;
      if (last) begin
        tail.done    = 1'b1;
        tail.len_err = (byte_count != limit_reg) || halted_early;
      end
      step_out[$] = tail;
    end
    if (last) clear_stream();
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stream generation
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic last);
    pending_bytes.push_back('{data: b, last: last});
  endfunction

  // builds one stream whose tokens decode to about `target` bytes
  function automatic int queue_stream(input int target, input stream_kind_t kind);
    logic [BYTE_W-1:0] s[$];
    logic [BYTE_W-1:0] flag_val;
    logic [WIN_AW-1:0] src;
    logic [WIN_AW-1:0] wp;
    int                want;
    int                produced;
    int                left;
    int                len;
    int                flag_idx;
    want     = target;
    produced = 0;
    if (kind == SK_OVER) want = target + $urandom_range(1, 20);
    else if (kind == SK_SHORT && target > 0) want = target - $urandom_range(1, target);
    if (kind == SK_NOISE) begin
      repeat ($urandom_range(1, 12)) s.push_back(BYTE_W'($urandom));
    end else begin
      while (produced < want) begin
        flag_idx = s.size();
        flag_val = BYTE_W'($urandom);     // unused bits stay random
        s.push_back('0);
        for (int k = 0; k < 8 && produced < want; k++) begin
          left = want - produced;
          wp   = WR_POS_INIT + WIN_AW'(produced);
          if (left < LEN_BIAS || $urandom_range(0, 2) == 0) begin
            flag_val[k] = 1'b1;
            s.push_back(BYTE_W'($urandom));
            produced++;
          end else begin
            len = $urandom_range(LEN_BIAS, (left < MAX_MATCH) ? left : MAX_MATCH);
            case ($urandom_range(0, 3))
              0, 1:    src = wp - WIN_AW'($urandom_range(1, 20));   // recent, may overlap
              2:       src = WIN_AW'($urandom);
              default: src = ($urandom_range(0, 1) != 0) ? '1 : '0;
            endcase
            flag_val[k] = 1'b0;
            s.push_back(src[7:0]);
            s.push_back({src[11:8], 4'(len - LEN_BIAS)});
            produced += len;
          end
        end
        s[flag_idx] = flag_val;
      end
      if (s.size() == 0) s.push_back(BYTE_W'($urandom));   // lone flag byte
      if (kind == SK_CUT && s.size() > 1) void'(s.pop_back());
    end
    foreach (s[i]) push_byte(s[i], i == s.size() - 1);
    return s.size();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one compressed byte per transaction, random gap after each
  // ---------------------------------------------------------------------------
  int   tx_gap  = 0;
  logic tx_calm = 1'b0;

  always @(posedge clk) begin
    comp_byte_t nxt;
    logic       take;
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= '0;
      in_if.last_in <= 1'b0;
      tx_gap = 0;
    end else begin
      take = in_if.valid && in_if.ready;
      if (take) begin
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 6);
      end
      if (!in_if.valid || take) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= nxt.data;
          in_if.last_in <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stall per result, plus one long hold-off while the
  // sender keeps offering, so the block backs up into its input
  // ---------------------------------------------------------------------------
  int   rx_gap    = 0;
  int   rx_count  = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic rx_calm   = 1'b0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        rx_count++;
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        rx_gap = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (!hold_done && rx_count >= HOLD_AFTER && in_if.valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track config writes, predict on input transactions, check output
  // transactions against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    decoded_t exp;
    if (!rst_n) begin
      limit_reg = '0;
      clear_stream();
      decoded_q.delete();
    end else begin
      if (cfg_we) limit_reg = cfg_data;
      if (in_if.valid && in_if.ready) decode_step(in_if.in_byte, in_if.last_in);
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: out_byte %0h", out_if.out_byte);
          mismatches++;
        end else begin
          exp = decoded_q.pop_front();
          check_field("out_byte",     exp.data,             out_if.out_byte);
          check_field("out_valid",    BYTE_W'(exp.valid),
                      BYTE_W'(out_if.out_valid));
          check_field("run_last",     BYTE_W'(exp.run_last),
                      BYTE_W'(out_if.run_last));
          check_field("done_res",     BYTE_W'(exp.done),
                      BYTE_W'(out_if.done_res));
          check_field("length_error", BYTE_W'(exp.len_err),
                      BYTE_W'(out_if.length_error));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  // block is idle once every byte is taken, every result is in, and any
  // result-less byte had time to finish
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_if.valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim;
    stream_kind_t       kind;
    int                 rand_items;
    int                 phase_no;
    int                 target;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.last_in = 1'b0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, limit 24
    write_limit(LIMIT_W'(24));
    // literal 00, overlapping 18-byte match, literal ff, match at offset 0,
    // literal a5 reaches the limit; next literal is refused, trailing byte is
    // input after stop
    push_byte(8'hF5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h3C, 1'b1);
    // stream ends with a pending match byte
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b1);
    // two 18-byte matches: second is cut at the limit, then input after stop
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'h34, 1'b1);
    // stream of a lone flag byte: single result without data
    push_byte(8'h80, 1'b1);
    wait_idle();

    // random part: phases of one to three streams, limit set per phase
    rand_items = 0;
    phase_no   = 0;
    while (rand_items < RAND_ITEMS) begin
      if (phase_no == 0) lim = '0;
      else if (phase_no == 1) lim = '1;
      else begin
        case ($urandom_range(0, 9))
          0:       lim = '0;
          1:       lim = '1;
          2:       lim = LIMIT_W'($urandom_range(49, BIG_LIMIT));
          default: lim = LIMIT_W'($urandom_range(1, 48));
        endcase
      end
      write_limit(lim);
      repeat ($urandom_range(1, 3)) begin
        target = (lim > BIG_LIMIT) ? $urandom_range(1, 40) : int'(lim);
        case ($urandom_range(0, 9))
          6:       kind = SK_OVER;
          7:       kind = SK_SHORT;
          8:       kind = SK_CUT;
          9:       kind = SK_NOISE;
          default: kind = SK_EXACT;
        endcase
        rand_items += queue_stream(target, kind);
      end
      wait_idle();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("lzss_stream_decompressor_top test passed");
    end else begin
      $display("lzss_stream_decompressor_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("lzss_stream_decompressor_top test failed");
    $finish;
  end

endmodule
